>>> hdl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the corridor box shrinking block: register
// indexes, side-band bit positions and the per-word control group.
// ----------------------------------------------------------------------------
package cbs_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W      = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_RADIUS = 2'd2;

  // Bit positions in the input tuser.
  localparam int unsigned USER_W     = 2;
  localparam int unsigned USER_FIRST = 0;
  localparam int unsigned USER_OBST  = 1;

  // Control group of a word leaving the rotation front end.
  typedef struct packed {
    logic valid;  // a word is present
    logic first;  // reload the bounds before use
    logic last;   // emit a box after use
    logic hit;    // obstacle lies strictly inside the search circle
  } cbs_ctrl_t;

endpackage

>>> hdl/corridor_box_shrink.sv
// ----------------------------------------------------------------------------
// corridor_box_shrink
// Shrinks one local corridor box per path point from a run of obstacle words
// and emits its bounds and world-frame face offsets.
// ----------------------------------------------------------------------------
// The block takes one word per clock unless the result side stalls it, and
// emits one box for each word that carries tlast. Each word passes an input
// register, a product register and a rounding register; the box bounds live
// in one set of registers that every word updates, and that update sets the
// one-word-per-cycle rate. A word with tuser[0] set reloads the bounds from
// the configuration first. The output register and the stage before it let
// words keep flowing while a box waits. Box length writes take effect at the
// next reload; the radii also feed the circle test and margin of later words.
// ----------------------------------------------------------------------------
module corridor_box_shrink
  import cbs_pkg::*;
#(
  parameter int COORD_BITS     = 24,
  parameter int TRIG_FRAC_BITS = 14,
  localparam int IN_W      = 4 * COORD_BITS + 2 * (TRIG_FRAC_BITS + 2),
  localparam int IN_PAD_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W     = 8 * COORD_BITS - 2,
  localparam int OUT_PAD_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-2:0] cfg_data,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // obstacle_x, obstacle_y, seed_x, seed_y, cos_heading, sin_heading
  input  logic [IN_PAD_W-1:0]   s_tdata,
  // first, has_obstacle
  input  logic [USER_W-1:0]     s_tuser,
  input  logic                  s_tlast,
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // bound_front, bound_back, bound_left, bound_right,
  // offset_front, offset_back, offset_left, offset_right
  output logic [OUT_PAD_W-1:0]  m_tdata
);

  localparam int CW = COORD_BITS;
  localparam int LW = CW + 4;
  localparam int EW = CW + 5;

  localparam logic [CW-1:0] TENTH = CW'(((1 << (CW / 2)) + 5) / 10);

  localparam logic [CW-2:0] RST_BOX_LENGTH  = (CW - 1)'(16384);
  localparam logic [CW-2:0] RST_SCAN_RADIUS = (CW - 1)'(12288);
  localparam logic [CW-2:0] RST_BODY_RADIUS = (CW - 1)'(2048);

  localparam logic signed [EW-1:0] SAT_MAX = EW'({1'b0, {(CW - 1){1'b1}}});
  localparam logic signed [EW-1:0] SAT_MIN = -EW'({1'b1, {(CW - 1){1'b0}}});

  // Clamp a wide sum to the signed coordinate range.
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    r = v;
    if (v > SAT_MAX) r = SAT_MAX;
    if (v < SAT_MIN) r = SAT_MIN;
    return r[CW-1:0];
  endfunction

  // Configuration registers.
  logic [CW-2:0] box_length, scan_radius, body_radius;
  logic [CW-1:0] margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length  <= RST_BOX_LENGTH;
      scan_radius <= RST_SCAN_RADIUS;
      body_radius <= RST_BODY_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_LENGTH:  box_length  <= cfg_data;
        REG_SCAN_RADIUS: scan_radius <= cfg_data;
        REG_BODY_RADIUS: body_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearance kept from an obstacle: robot radius plus a tenth of a metre.
  always_ff @(posedge clk) begin
    margin <= CW'(body_radius) + TENTH;
  end

  // Rotation front end.
  cbs_ctrl_t                rot_ctrl;
  logic signed [LW-1:0]     rot_lx, rot_ly, rot_p, rot_q;
  logic                     rdy4, rdy5, fire3;

  cbs_rotate #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .clk         (clk),
    .rst         (rst),
    .scan_radius (scan_radius),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_data     (s_tdata),
    .in_user     (s_tuser),
    .in_last     (s_tlast),
    .out_ready   (rdy4),
    .out_ctrl    (rot_ctrl),
    .out_lx      (rot_lx),
    .out_ly      (rot_ly),
    .out_p       (rot_p),
    .out_q       (rot_q)
  );

  logic v4, v5;

  assign rdy5  = !v5 || m_tready;
  assign rdy4  = !v4 || rdy5;
  assign fire3 = rot_ctrl.valid && rdy4;

  // Box bounds in the local frame.
  logic signed [CW-1:0] front_ext, back_ext, left_ext, right_ext;
  logic signed [CW-1:0] front_next, back_next, left_next, right_next;

  // Bound update: lateral shrink first, then longitudinal with new sides.
  always_comb begin
    logic signed [EW-1:0] f0, b0, l0, r0, l1, r1, f1, b1;
    logic signed [EW-1:0] px, py, m, half, rad, v;
    half = EW'({1'b0, box_length[CW-2:1]});
    rad  = EW'({1'b0, scan_radius});
    m    = EW'({1'b0, margin});
    px   = EW'(rot_lx);
    py   = EW'(rot_ly);
    v    = '0;
    if (rot_ctrl.first) begin
      f0 = half;
      b0 = -half;
      l0 = rad;
      r0 = -rad;
    end else begin
      f0 = EW'(front_ext);
      b0 = EW'(back_ext);
      l0 = EW'(left_ext);
      r0 = EW'(right_ext);
    end
    l1 = l0;
    r1 = r0;
    if (rot_ctrl.hit && px > b0 && px < f0) begin
      if (py > 0 && py < l0) begin
        v  = py - m;
        l1 = (v > 0) ? v : '0;
      end else if (py < 0 && py > r0) begin
        v  = py + m;
        r1 = (v < 0) ? v : '0;
      end
    end
    f1 = f0;
    b1 = b0;
    if (rot_ctrl.hit && py > r1 && py < l1) begin
      if (px > 0 && px < f0) begin
        v  = px - m;
        f1 = (v > 0) ? v : '0;
      end else if (px < 0 && px > b0) begin
        v  = px + m;
        b1 = (v < 0) ? v : '0;
      end
    end
    front_next = f1[CW-1:0];
    back_next  = b1[CW-1:0];
    left_next  = l1[CW-1:0];
    right_next = r1[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ext <= $signed({1'b0, RST_BOX_LENGTH[CW-2:1]}) ;
      back_ext  <= -$signed({1'b0, RST_BOX_LENGTH[CW-2:1]});
      left_ext  <= $signed({1'b0, RST_SCAN_RADIUS});
      right_ext <= -$signed({1'b0, RST_SCAN_RADIUS});
    end else if (fire3) begin
      front_ext <= front_next;
      back_ext  <= back_next;
      left_ext  <= left_next;
      right_ext <= right_next;
    end
  end

  // Result stage: snapshot of the finished box and the seed projections.
  logic signed [CW-1:0] front4, back4, left4, right4;
  logic signed [LW-1:0] p4, q4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= rot_ctrl.valid && rot_ctrl.last;
    end
    if (rdy4) begin
      front4 <= front_next;
      back4  <= back_next;
      left4  <= left_next;
      right4 <= right_next;
      p4     <= rot_p;
      q4     <= rot_q;
    end
  end

  // Output register: face offsets saturate to the coordinate range.
  logic signed [CW-1:0] off_front, off_back, off_left, off_right;

  always_comb begin
    off_front = sat_coord(EW'(front4) + EW'(p4));
    off_back  = sat_coord(-EW'(back4) - EW'(p4));
    off_left  = sat_coord(EW'(left4) + EW'(q4));
    off_right = sat_coord(-EW'(right4) - EW'(q4));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
    if (rdy5) begin
      m_tdata <= OUT_PAD_W'({off_right, off_left, off_back, off_front,
                             right4, left4[CW-2:0], back4, front4[CW-2:0]});
    end
  end

  assign m_tvalid = v5;

`ifndef SYNTHESIS
  // Stored bounds always keep their sides of the seed.
  a_bound_signs: assert property (@(posedge clk) disable iff (rst)
    (front_ext >= 0) && (left_ext >= 0) && (back_ext <= 0) && (right_ext <= 0))
    else $error("box bound on the wrong side of the seed");

  // Without a reload, a word can only tighten the box.
  a_only_shrinks: assert property (@(posedge clk) disable iff (rst)
    fire3 && !rot_ctrl.first |=>
      (front_ext <= $past(front_ext)) && (left_ext <= $past(left_ext)) &&
      (back_ext >= $past(back_ext)) && (right_ext >= $past(right_ext)))
    else $error("box grew without a reload");

  // A box only shows up after a last word reached the result stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v4))
    else $error("result without a finished box");
`endif

endmodule

>>> hdl/cbs_rotate.sv
// ----------------------------------------------------------------------------
// cbs_rotate
// Three-stage front end: captures a word, forms the obstacle offset and all
// products, then rounds the rotated coordinates and tests the search circle.
// ----------------------------------------------------------------------------
module cbs_rotate
  import cbs_pkg::*;
#(
  parameter int COORD_BITS     = 24,
  parameter int TRIG_FRAC_BITS = 14,
  localparam int IN_W     = 4 * COORD_BITS + 2 * (TRIG_FRAC_BITS + 2),
  localparam int IN_PAD_W = ((IN_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [COORD_BITS-2:0]            scan_radius,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [IN_PAD_W-1:0]              in_data,
  input  logic [USER_W-1:0]                in_user,
  input  logic                             in_last,
  input  logic                             out_ready,
  output cbs_ctrl_t                        out_ctrl,
  output logic signed [COORD_BITS+3:0]     out_lx,
  output logic signed [COORD_BITS+3:0]     out_ly,
  output logic signed [COORD_BITS+3:0]     out_p,
  output logic signed [COORD_BITS+3:0]     out_q
);

  localparam int CW = COORD_BITS;
  localparam int T  = TRIG_FRAC_BITS;
  localparam int TW = T + 2;
  localparam int DW = CW + 1;
  localparam int PW = DW + TW;
  localparam int SW = PW + 1;
  localparam int QW = 2 * CW;

  localparam logic signed [TW-1:0] TRIG_ONE  = {2'b01, {T{1'b0}}};
  localparam logic signed [TW-1:0] TRIG_MONE = {2'b11, {T{1'b0}}};
  localparam logic signed [SW-1:0] ROUND_HALF =
    {{(SW - T){1'b0}}, 1'b1, {(T - 1){1'b0}}};

  // Saturate a heading component to [-1.0, +1.0].
  function automatic logic signed [TW-1:0] clamp_trig(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] r;
    r = v;
    if (v > TRIG_ONE) r = TRIG_ONE;
    if (v < TRIG_MONE) r = TRIG_MONE;
    return r;
  endfunction

  // Field slices of the input word.
  logic signed [CW-1:0] obs_x, obs_y, seed_x, seed_y;
  logic signed [TW-1:0] cos_in, sin_in;

  assign obs_x  = $signed(in_data[CW-1:0]);
  assign obs_y  = $signed(in_data[2*CW-1:CW]);
  assign seed_x = $signed(in_data[3*CW-1:2*CW]);
  assign seed_y = $signed(in_data[4*CW-1:3*CW]);
  assign cos_in = $signed(in_data[4*CW+TW-1:4*CW]);
  assign sin_in = $signed(in_data[4*CW+2*TW-1:4*CW+TW]);

  // Handshake chain: a stage loads when it is empty or its word moves on.
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Squared search radius, refreshed every cycle from the register.
  logic [QW-3:0] radius_sq;

  always_ff @(posedge clk) begin
    radius_sq <= (QW - 2)'(scan_radius) * (QW - 2)'(scan_radius);
  end

  // Stage 1: capture, offset to the seed and trig saturation.
  logic                 f1, l1, o1;
  logic signed [DW-1:0] dx1, dy1, sx1, sy1;
  logic signed [TW-1:0] c1, s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      f1  <= in_user[USER_FIRST];
      o1  <= in_user[USER_OBST];
      l1  <= in_last;
      dx1 <= DW'(obs_x) - DW'(seed_x);
      dy1 <= DW'(obs_y) - DW'(seed_y);
      sx1 <= DW'(seed_x);
      sy1 <= DW'(seed_y);
      c1  <= clamp_trig(cos_in);
      s1  <= clamp_trig(sin_in);
    end
  end

  // Stage 2: all products, one multiplier each.
  logic                   f2, l2, o2;
  logic signed [PW-1:0]   p_cdx, p_sdy, p_cdy, p_sdx;
  logic signed [PW-1:0]   p_csx, p_ssy, p_csy, p_ssx;
  logic signed [2*DW-1:0] p_dx2, p_dy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      f2    <= f1;
      l2    <= l1;
      o2    <= o1;
      p_cdx <= PW'(c1) * PW'(dx1);
      p_sdy <= PW'(s1) * PW'(dy1);
      p_cdy <= PW'(c1) * PW'(dy1);
      p_sdx <= PW'(s1) * PW'(dx1);
      p_csx <= PW'(c1) * PW'(sx1);
      p_ssy <= PW'(s1) * PW'(sy1);
      p_csy <= PW'(c1) * PW'(sy1);
      p_ssx <= PW'(s1) * PW'(sx1);
      p_dx2 <= (2 * DW)'(dx1) * (2 * DW)'(dx1);
      p_dy2 <= (2 * DW)'(dy1) * (2 * DW)'(dy1);
    end
  end

  // Rotated sums with round half up; arithmetic shift is a bit select.
  logic signed [SW-1:0] sum_lx, sum_ly, sum_p, sum_q;
  logic [QW:0]          dist_sq;

  always_comb begin
    sum_lx  = SW'(p_cdx) + SW'(p_sdy) + ROUND_HALF;
    sum_ly  = SW'(p_cdy) - SW'(p_sdx) + ROUND_HALF;
    sum_p   = SW'(p_csx) + SW'(p_ssy) + ROUND_HALF;
    sum_q   = SW'(p_csy) - SW'(p_ssx) + ROUND_HALF;
    dist_sq = {1'b0, p_dx2[QW-1:0]} + {1'b0, p_dy2[QW-1:0]};
  end

  // Stage 3: rounded local coordinates and the inside test.
  logic f3, l3, h3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      f3     <= f2;
      l3     <= l2;
      h3     <= o2 && (dist_sq < (QW + 1)'(radius_sq));
      out_lx <= $signed(sum_lx[SW-1:T]);
      out_ly <= $signed(sum_ly[SW-1:T]);
      out_p  <= $signed(sum_p[SW-1:T]);
      out_q  <= $signed(sum_q[SW-1:T]);
    end
  end

  assign out_ctrl = '{valid: v3, first: f3, last: l3, hit: h3};

endmodule

>>> tb/corridor_box_shrink_test.sv
// ----------------------------------------------------------------------------
// corridor_box_shrink_test
// Self-checking bench for the corridor box shrinking block. A queue of pending
// obstacle words feeds a clocked driver; every accepted word runs through a
// bit-accurate box predictor, and a clocked monitor compares each box that
// leaves the block with the oldest predicted box. Several register settings
// are visited, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module corridor_box_shrink_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbs_pkg::*;

  localparam int CB        = 24;
  localparam int TF        = 14;
  localparam int TW        = TF + 2;
  localparam int IN_PAD_W  = 128;
  localparam int OUT_W     = 8 * CB - 2;
  localparam int OUT_PAD_W = 192;

  localparam longint TENTH    = ((longint'(1) << (CB / 2)) + 5) / 10;
  localparam longint TRIG_ONE = longint'(1) << TF;
  localparam longint SMAX     = (longint'(1) << (CB - 1)) - 1;
  localparam longint SMIN     = -(longint'(1) << (CB - 1));
  localparam longint UMAX     = (longint'(1) << (CB - 1)) - 1;

  // Register index past the end of the register file; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Cycles to let pass after the last box so that trailing words drain.
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 100;

  // One input word as the block sees it.
  typedef struct packed {
    logic          first;
    logic          last;
    logic          has_obstacle;
    logic [CB-1:0] obstacle_x;
    logic [CB-1:0] obstacle_y;
    logic [CB-1:0] seed_x;
    logic [CB-1:0] seed_y;
    logic [TW-1:0] cos_heading;
    logic [TW-1:0] sin_heading;
  } obs_word_t;

  // One box; members run from the top of m_tdata down so a cast unpacks it.
  typedef struct packed {
    logic [CB-1:0] offset_right;
    logic [CB-1:0] offset_left;
    logic [CB-1:0] offset_back;
    logic [CB-1:0] offset_front;
    logic [CB-1:0] bound_right;
    logic [CB-2:0] bound_left;
    logic [CB-1:0] bound_back;
    logic [CB-2:0] bound_front;
  } box_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CB-2:0]        cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // obstacle_x, obstacle_y, seed_x, seed_y, cos_heading, sin_heading
  logic [IN_PAD_W-1:0]  s_tdata = '0;
  // first, has_obstacle
  logic [USER_W-1:0]    s_tuser = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // bound_front, bound_back, bound_left, bound_right,
  // offset_front, offset_back, offset_left, offset_right
  logic [OUT_PAD_W-1:0] m_tdata;

  // Register copies and box state of the predictor.
  logic [CB-2:0]        reg_box_length  = 23'd16384;
  logic [CB-2:0]        reg_scan_radius = 23'd12288;
  logic [CB-2:0]        reg_body_radius = 23'd2048;
  logic signed [CB-1:0] front_ext = 24'sd8192;
  logic signed [CB-1:0] back_ext  = -24'sd8192;
  logic signed [CB-1:0] left_ext  = 24'sd12288;
  logic signed [CB-1:0] right_ext = -24'sd12288;

  obs_word_t pending_words[$];
  box_t      expected_boxes[$];
  obs_word_t cur_word;
  box_t      got_box;
  box_t      want_box;
  int        n_pushed = 0;
  int        n_accepted = 0;
  int        n_errors = 0;
  int        in_gap = 0;
  int        out_stall = 0;
  bit        steady_flow = 1'b0;

  corridor_box_shrink i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round a trig product sum back to coordinate scale, ties toward +infinity.
  function automatic longint rnd_shift(longint v);
    return (v + (longint'(1) << (TF - 1))) >>> TF;
  endfunction

  // Cos and sin are limited to [-1.0, +1.0] before use.
  function automatic longint trig_clamp(logic [TW-1:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > TRIG_ONE) return TRIG_ONE;
    if (v < -TRIG_ONE) return -TRIG_ONE;
    return v;
  endfunction

  function automatic logic [CB-1:0] sat_coord(longint v);
    logic [CB-1:0] r;
    if (v > SMAX) r = CB'(SMAX);
    else if (v < SMIN) r = CB'(SMIN);
    else r = CB'(v);
    return r;
  endfunction

  // Apply one accepted word to the box state and queue the box it emits.
  function automatic void predict_box(obs_word_t w);
    longint ox, oy, sx, sy, c, s, dx, dy, r, lx, ly, margin, v, p, q;
    longint fe, be, le, re;
    box_t b;
    ox = longint'($signed(w.obstacle_x));
    oy = longint'($signed(w.obstacle_y));
    sx = longint'($signed(w.seed_x));
    sy = longint'($signed(w.seed_y));
    c  = trig_clamp(w.cos_heading);
    s  = trig_clamp(w.sin_heading);
    if (w.first) begin
      fe = longint'(reg_box_length >> 1);
      be = -fe;
      le = longint'(reg_scan_radius);
      re = -le;
    end else begin
      fe = longint'(front_ext);
      be = longint'(back_ext);
      le = longint'(left_ext);
      re = longint'(right_ext);
    end
    if (w.has_obstacle) begin
      dx = ox - sx;
      dy = oy - sy;
      r  = longint'(reg_scan_radius);
      // Only obstacles strictly inside the search circle count.
      if (dx * dx + dy * dy < r * r) begin
        lx = rnd_shift(c * dx + s * dy);
        ly = rnd_shift(c * dy - s * dx);
        margin = longint'(reg_body_radius) + TENTH;
        // Lateral bound first, then the longitudinal one with updated sides.
        if (lx > be && lx < fe) begin
          if (ly > 0 && ly < le) begin
            v = ly - margin;
            le = (v > 0) ? v : 0;
          end else if (ly < 0 && ly > re) begin
            v = ly + margin;
            re = (v < 0) ? v : 0;
          end
        end
        if (ly > re && ly < le) begin
          if (lx > 0 && lx < fe) begin
            v = lx - margin;
            fe = (v > 0) ? v : 0;
          end else if (lx < 0 && lx > be) begin
            v = lx + margin;
            be = (v < 0) ? v : 0;
          end
        end
      end
    end
    front_ext = CB'(fe);
    back_ext  = CB'(be);
    left_ext  = CB'(le);
    right_ext = CB'(re);
    if (w.last) begin
      p = rnd_shift(c * sx + s * sy);
      q = rnd_shift(c * sy - s * sx);
      b.bound_front  = (CB - 1)'(fe);
      b.bound_back   = CB'(be);
      b.bound_left   = (CB - 1)'(le);
      b.bound_right  = CB'(re);
      b.offset_front = sat_coord(fe + p);
      b.offset_back  = sat_coord(-be - p);
      b.offset_left  = sat_coord(le + q);
      b.offset_right = sat_coord(-re - q);
      expected_boxes = {expected_boxes, b};
    end
  endfunction

  // Gap length for either stream side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [CB-1:0] want, logic [CB-1:0] got);
    if (got !== want) begin
      if (n_errors < MAX_REPORTS)
        $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Input driver: presents pending words, predicts each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_box(cur_word);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_word.sin_heading, cur_word.cos_heading,
                       cur_word.seed_y, cur_word.seed_x,
                       cur_word.obstacle_y, cur_word.obstacle_x};
          s_tuser  <= {cur_word.has_obstacle, cur_word.first};
          s_tlast  <= cur_word.last;
          in_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks every box taken and stalls the result side.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_box = box_t'(m_tdata[OUT_W-1:0]);
        if (expected_boxes.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $error("box word arrived with no box predicted");
          n_errors++;
        end else begin
          want_box = expected_boxes.pop_front();
          check_field("bound_front", want_box.bound_front, got_box.bound_front);
          check_field("bound_back", want_box.bound_back, got_box.bound_back);
          check_field("bound_left", want_box.bound_left, got_box.bound_left);
          check_field("bound_right", want_box.bound_right, got_box.bound_right);
          check_field("offset_front", want_box.offset_front, got_box.offset_front);
          check_field("offset_back", want_box.offset_back, got_box.offset_back);
          check_field("offset_left", want_box.offset_left, got_box.offset_left);
          check_field("offset_right", want_box.offset_right, got_box.offset_right);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  task automatic add_word(input bit f, input bit l, input bit h,
                          input longint ox, input longint oy,
                          input longint sx, input longint sy,
                          input longint c, input longint s);
    obs_word_t w;
    w.first        = f;
    w.last         = l;
    w.has_obstacle = h;
    w.obstacle_x   = CB'(ox);
    w.obstacle_y   = CB'(oy);
    w.seed_x       = CB'(sx);
    w.seed_y       = CB'(sy);
    w.cos_heading  = TW'(c);
    w.sin_heading  = TW'(s);
    pending_words = {pending_words, w};
    n_pushed++;
  endtask

  // Wait until every word is taken and every box has come, then drain.
  task automatic settle();
    while (n_accepted != n_pushed || expected_boxes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (CB - 1)'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_BOX_LENGTH:  reg_box_length  = (CB - 1)'(value);
      REG_SCAN_RADIUS: reg_scan_radius = (CB - 1)'(value);
      REG_BODY_RADIUS: reg_body_radius = (CB - 1)'(value);
      default: ;
    endcase
  endtask

  task automatic set_regs(input longint box_len, input longint radius, input longint robot);
    write_reg(REG_BOX_LENGTH, box_len);
    write_reg(REG_SCAN_RADIUS, radius);
    write_reg(REG_BODY_RADIUS, robot);
    // Out-of-range index; must leave all registers alone.
    write_reg(REG_UNUSED, longint'($urandom));
  endtask

  // Hand-picked runs under the reset register values.
  task automatic directed_runs();
    // One-word run with no obstacle: the unshrunk box at the origin.
    add_word(1, 1, 0, 0, 0, 0, 0, TRIG_ONE, 0);
    // Front, left and right shrinks, then an obstacle with its flag clear.
    add_word(1, 0, 1, 4096, 0, 0, 0, TRIG_ONE, 0);
    add_word(0, 0, 1, 0, 2000, 0, 0, TRIG_ONE, 0);
    add_word(0, 0, 1, -4096, -3000, 0, 0, TRIG_ONE, 0);
    add_word(0, 1, 0, 1000, 1000, 0, 0, TRIG_ONE, 0);
    // Obstacle exactly on the circle, then back and right shrinks.
    add_word(1, 0, 1, 1000 + 12288, -1000, 1000, -1000, TRIG_ONE, 0);
    add_word(0, 0, 1, 1000 - 4000, -1000, 1000, -1000, TRIG_ONE, 0);
    add_word(0, 0, 1, 1000 + 12287, -1000, 1000, -1000, TRIG_ONE, 0);
    add_word(0, 1, 1, 1000, -1000 - 3000, 1000, -1000, TRIG_ONE, 0);
    // Run without a reload: bounds carry on.
    add_word(0, 1, 1, 5000, 5000, 0, 0, TRIG_ONE, 0);
    // Extreme seeds and obstacle fields; offsets saturate both ways.
    add_word(1, 1, 1, SMIN, SMAX, SMAX, SMAX, TRIG_ONE, TRIG_ONE);
    add_word(1, 1, 1, SMAX, SMIN, SMIN, SMIN, -TRIG_ONE, -TRIG_ONE);
    add_word(1, 1, 0, SMAX, SMAX, SMAX, SMIN, -TRIG_ONE, TRIG_ONE);
    // Trig beyond one is clamped.
    add_word(1, 0, 1, 100, 200, 0, 0, 16'h7fff, 16'h8000);
    add_word(0, 1, 1, -300, 2500, 0, 0, 16'h8000, 16'h7fff);
    // Quarter turn: a world +y obstacle lies ahead in the local frame.
    add_word(1, 1, 1, 0, 3000, 0, 0, 0, TRIG_ONE);
    // All four quadrants near the seed.
    add_word(1, 0, 1, 3000, 3000, 0, 0, TRIG_ONE, 0);
    add_word(0, 0, 1, -3000, 3000, 0, 0, TRIG_ONE, 0);
    add_word(0, 0, 1, -3000, -3000, 0, 0, TRIG_ONE, 0);
    add_word(0, 1, 1, 3000, -3000, 0, 0, TRIG_ONE, 0);
  endtask

  // One random run: mostly well-formed, now and then a word of pure noise.
  task automatic random_run(output int cnt);
    int     len;
    longint r, sx, sy, c, s, ox, oy;
    bit     f, l, h;
    real    a;
    r = longint'(reg_scan_radius);
    cnt = 0;
    if ($urandom_range(0, 9) == 0) begin
      add_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)),
               longint'($urandom), longint'($urandom), longint'($urandom),
               longint'($urandom), longint'($urandom), longint'($urandom));
      cnt = 1;
    end else begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 14);
      if ($urandom_range(0, 9) < 8) begin
        sx = longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
        sy = longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
      end else begin
        sx = longint'($urandom);
        sy = longint'($urandom);
      end
      case ($urandom_range(0, 19))
        0, 1: begin
          c = longint'($urandom);
          s = longint'($urandom);
        end
        2: begin
          c = $urandom_range(0, 1) ? TRIG_ONE : -TRIG_ONE;
          s = 0;
        end
        3: begin
          c = 0;
          s = $urandom_range(0, 1) ? TRIG_ONE : -TRIG_ONE;
        end
        default: begin
          a = real'($urandom_range(0, 62831)) / 10000.0;
          c = $rtoi($cos(a) * 16384.0);
          s = $rtoi($sin(a) * 16384.0);
        end
      endcase
      for (int k = 0; k < len; k++) begin
        f = (k == 0) && ($urandom_range(0, 9) != 0);
        l = (k == len - 1) && ($urandom_range(0, 19) != 0);
        h = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 9))
          8: begin
            ox = sx + longint'($urandom_range(0, 4 * r)) - 2 * r;
            oy = sy + longint'($urandom_range(0, 4 * r)) - 2 * r;
          end
          9: begin
            ox = longint'($urandom);
            oy = longint'($urandom);
          end
          default: begin
            ox = sx + longint'($urandom_range(0, 2 * r)) - r;
            oy = sy + longint'($urandom_range(0, 2 * r)) - r;
          end
        endcase
        add_word(f, l, h, ox, oy, sx, sy, c, s);
      end
      cnt = len;
    end
  endtask

  // Stimulus sequence: phases of register settings, each run to idle.
  initial begin
    int n;
    int cnt;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      steady_flow = (ph == 3 || ph == 6);
      case (ph)
        1: set_regs(40960, 20480, 1024);
        2: set_regs(UMAX, UMAX, UMAX);
        3: set_regs(0, 0, 0);
        4: set_regs(1, 4096, 0);
        5: set_regs(longint'($urandom_range(0, 2 ** 17)),
                    longint'($urandom_range(1, 2 ** 16)),
                    longint'($urandom_range(0, 2 ** 14)));
        6: set_regs(longint'($urandom_range(0, UMAX)), longint'($urandom_range(0, UMAX)),
                    longint'($urandom_range(0, UMAX)));
        default: ;
      endcase
      if (ph == 0)
        directed_runs();
      n = 0;
      while (n < 285) begin
        random_run(cnt);
        n += cnt;
      end
      settle();
    end
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(10_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
